>>> hw/rtl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// Depends on nothing; every other file of the block imports it.
package rau_pkg;

   // Fixed field widths of the item formats.
   localparam int OPER_BITS = 32;
   localparam int WIDE_BITS = 64;
   localparam int SHIFT_BITS = 6;
   localparam int COUNT_BITS = 6;

   // Action codes.
   localparam logic [2:0] ACT_NORM = 3'd0;
   localparam logic [2:0] ACT_ADD  = 3'd1;
   localparam logic [2:0] ACT_SUB  = 3'd2;
   localparam logic [2:0] ACT_MUL  = 3'd3;
   localparam logic [2:0] ACT_DIV  = 3'd4;
   localparam logic [2:0] ACT_CMP  = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // Product steps of the shared multiplier.
   localparam logic [1:0] MUL_P  = 2'd0;
   localparam logic [1:0] MUL_Q  = 2'd1;
   localparam logic [1:0] MUL_DD = 2'd2;
   localparam logic [1:0] MUL_NN = 2'd3;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] left_num;
      logic signed [31:0] left_den;
      logic signed [31:0] right_num;
      logic signed [31:0] right_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic [30:0]        result_den;
      logic               is_less;
      logic               is_equal;
      logic [1:0]         status;
   } rsp_type;

   // Classified item passed from the front end to the back end.
   typedef struct packed {
      logic [2:0]           action;
      logic                 early;
      logic [1:0]           early_status;
      logic                 ln_neg;
      logic                 ld_neg;
      logic                 rn_neg;
      logic                 rd_neg;
      logic [OPER_BITS-1:0] lnm;
      logic [OPER_BITS-1:0] ldm;
      logic [OPER_BITS-1:0] rnm;
      logic [OPER_BITS-1:0] rdm;
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_COMB,
      S_GCD,
      S_DIV,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/rau_front.sv
// Front end: takes an item, sign-extends the operands, splits sign and
// magnitude and decides which items finish at once. Depends on rau_pkg.
module rau_front #(
   parameter int DATA_BITS = 32
) (
   input  logic            start,
   input  logic            full,
   input  rau_pkg::req_type req_data,
   output logic            push,
   output rau_pkg::job_type job
);
   import rau_pkg::*;

   // Sign of a DATA_BITS-bit operand.
   function automatic logic sign_of(input logic [OPER_BITS-1:0] raw);
      logic signed [DATA_BITS-1:0] t;
      t = raw[DATA_BITS-1:0];
      return t[DATA_BITS-1];
   endfunction

   // Magnitude of a DATA_BITS-bit operand, sign-extended first.
   function automatic logic [OPER_BITS-1:0] mag_of(input logic [OPER_BITS-1:0] raw);
      logic signed [DATA_BITS-1:0] t;
      logic signed [OPER_BITS-1:0] v;
      t = raw[DATA_BITS-1:0];
      v = OPER_BITS'(t);
      return v[OPER_BITS-1] ? OPER_BITS'(-v) : OPER_BITS'(v);
   endfunction

   logic ld_zero;
   logic rd_zero;

   assign push = start && !full;

   // Classification of one item.
   always_comb begin
      job.action = req_data.action;
      job.ln_neg = sign_of(req_data.left_num);
      job.ld_neg = sign_of(req_data.left_den);
      job.rn_neg = sign_of(req_data.right_num);
      job.rd_neg = sign_of(req_data.right_den);
      job.lnm = mag_of(req_data.left_num);
      job.ldm = mag_of(req_data.left_den);
      job.rnm = mag_of(req_data.right_num);
      job.rdm = mag_of(req_data.right_den);
      ld_zero = (job.ldm == '0);
      rd_zero = (job.rdm == '0);
      job.early = 1'b0;
      job.early_status = ST_OK;
      if (req_data.action > ACT_CMP) begin
         job.early = 1'b1;
      end else if (ld_zero || (req_data.action != ACT_NORM && rd_zero)) begin
         job.early = 1'b1;
         job.early_status = ST_ZERO_DEN;
      end
   end

endmodule

>>> hw/rtl/rau_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on rau_pkg.
module rau_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rau_pkg::job_type push_job,
   input  logic            pop,
   output logic            full,
   output logic            empty,
   output rau_pkg::job_type head
);
   import rau_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/rau_back.sv
// Back end: cross products on one multiplier, binary gcd, two restoring
// dividers and the range check. Depends on rau_pkg.
module rau_back #(
   parameter int DATA_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            empty,
   input  rau_pkg::job_type head,
   output logic            pop,
   output logic            rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   localparam logic [WIDE_BITS-1:0] HALF = WIDE_BITS'(1) << (DATA_BITS - 1);

   state_type             state_ff, state_in;
   job_type               job_ff, job_in;
   logic [1:0]            step_ff, step_in;
   logic [WIDE_BITS-1:0]  p_ff, p_in, q_ff, q_in, dd_ff, dd_in, nn_ff, nn_in;
   logic                  neg_ff, neg_in;
   logic [1:0]            stat_ff, stat_in;
   logic                  less_ff, less_in, equal_ff, equal_in;
   logic [WIDE_BITS-1:0]  ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in;
   logic [SHIFT_BITS-1:0] k_ff, k_in;
   logic [WIDE_BITS-1:0]  qa_ff, qa_in, qb_ff, qb_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [OPER_BITS-1:0]  mul_a, mul_b;
   logic [WIDE_BITS-1:0]  prod;
   logic                  aneg, bneg, bsign;
   logic                  cneg;
   logic [WIDE_BITS-1:0]  cmag, cden;
   logic                  div_zero;
   logic [WIDE_BITS-1:0]  sh_a, sh_b;
   logic [WIDE_BITS-1:0]  limit;
   logic                  fits;
   logic [OPER_BITS-1:0]  mag_lo;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Shared multiplier, one product per cycle.
   always_comb begin
      case (step_ff)
         MUL_P: begin
            mul_a = job_ff.lnm;
            mul_b = job_ff.rdm;
         end
         MUL_Q: begin
            mul_a = job_ff.rnm;
            mul_b = job_ff.ldm;
         end
         MUL_DD: begin
            mul_a = job_ff.ldm;
            mul_b = job_ff.rdm;
         end
         default: begin
            mul_a = job_ff.lnm;
            mul_b = job_ff.rnm;
         end
      endcase
      prod = WIDE_BITS'(mul_a) * WIDE_BITS'(mul_b);
   end

   // Signed combination of the products into an unreduced fraction.
   always_comb begin
      aneg = (job_ff.ln_neg ^ job_ff.ld_neg) && (job_ff.lnm != '0);
      bneg = (job_ff.rn_neg ^ job_ff.rd_neg) && (job_ff.rnm != '0);
      bsign = bneg ^ (job_ff.action == ACT_SUB);
      cneg = 1'b0;
      cmag = '0;
      cden = WIDE_BITS'(1);
      div_zero = 1'b0;
      case (job_ff.action)
         ACT_NORM: begin
            cneg = aneg;
            cmag = WIDE_BITS'(job_ff.lnm);
            cden = WIDE_BITS'(job_ff.ldm);
         end
         ACT_ADD, ACT_SUB: begin
            cden = dd_ff;
            if (aneg == bsign) begin
               cneg = aneg;
               cmag = p_ff + q_ff;
            end else if (p_ff >= q_ff) begin
               cneg = aneg;
               cmag = p_ff - q_ff;
            end else begin
               cneg = bsign;
               cmag = q_ff - p_ff;
            end
         end
         ACT_MUL: begin
            cneg = aneg ^ bneg;
            cmag = nn_ff;
            cden = dd_ff;
         end
         ACT_DIV: begin
            div_zero = (job_ff.rnm == '0);
            cneg = aneg ^ bneg;
            cmag = p_ff;
            cden = q_ff;
         end
         default: begin
         end
      endcase
   end

   // Range check of the reduced result.
   always_comb begin
      limit = neg_ff ? HALF : HALF - WIDE_BITS'(1);
      fits = (qa_ff <= limit) && (qb_ff <= HALF - WIDE_BITS'(1));
      mag_lo = qa_ff[OPER_BITS-1:0];
      sh_a = {ra_ff[WIDE_BITS-2:0], qa_ff[WIDE_BITS-1]};
      sh_b = {rb_ff[WIDE_BITS-2:0], qb_ff[WIDE_BITS-1]};
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      step_in = step_ff;
      p_in = p_ff;
      q_in = q_ff;
      dd_in = dd_ff;
      nn_in = nn_ff;
      neg_in = neg_ff;
      stat_in = stat_ff;
      less_in = less_ff;
      equal_in = equal_ff;
      ga_in = ga_ff;
      gb_in = gb_ff;
      g_in = g_ff;
      k_in = k_ff;
      qa_in = qa_ff;
      qb_in = qb_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               job_in = head;
               step_in = MUL_P;
               stat_in = head.early_status;
               neg_in = 1'b0;
               less_in = 1'b0;
               equal_in = 1'b0;
               qa_in = '0;
               qb_in = WIDE_BITS'(1);
               state_in = head.early ? S_DONE : S_MUL;
            end
         end
         S_MUL: begin
            case (step_ff)
               MUL_P: p_in = prod;
               MUL_Q: q_in = prod;
               MUL_DD: dd_in = prod;
               default: nn_in = prod;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == MUL_NN) begin
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            if (job_ff.action == ACT_CMP) begin
               equal_in = (aneg == bneg) && (p_ff == q_ff);
               if (aneg != bneg) begin
                  less_in = aneg;
               end else if (aneg) begin
                  less_in = (p_ff > q_ff);
               end else begin
                  less_in = (p_ff < q_ff);
               end
            end
            ga_in = cmag;
            gb_in = cden;
            k_in = '0;
            qa_in = cmag;
            qb_in = cden;
            neg_in = cneg;
            if (div_zero) begin
               stat_in = ST_DIV_ZERO;
               state_in = S_DONE;
            end else if (cmag == '0) begin
               neg_in = 1'b0;
               qa_in = '0;
               qb_in = WIDE_BITS'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // One binary gcd step per cycle.
            if (ga_ff == '0 || gb_ff == '0) begin
               g_in = (ga_ff | gb_ff) << k_ff;
               ra_in = '0;
               rb_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in = k_ff + SHIFT_BITS'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         S_DIV: begin
            // Numerator and denominator divided by the gcd, one bit a cycle.
            if (sh_a >= g_ff) begin
               ra_in = sh_a - g_ff;
               qa_in = {qa_ff[WIDE_BITS-2:0], 1'b1};
            end else begin
               ra_in = sh_a;
               qa_in = {qa_ff[WIDE_BITS-2:0], 1'b0};
            end
            if (sh_b >= g_ff) begin
               rb_in = sh_b - g_ff;
               qb_in = {qb_ff[WIDE_BITS-2:0], 1'b1};
            end else begin
               rb_in = sh_b;
               qb_in = {qb_ff[WIDE_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + COUNT_BITS'(1);
            if (cnt_ff == COUNT_BITS'(WIDE_BITS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            if (stat_ff != ST_OK || !fits) begin
               rsp_in.status = (stat_ff != ST_OK) ? stat_ff : ST_OVERFLOW;
               rsp_in.result_num = '0;
               rsp_in.result_den = '0;
               rsp_in.is_less = 1'b0;
               rsp_in.is_equal = 1'b0;
            end else begin
               rsp_in.status = ST_OK;
               rsp_in.result_num = neg_ff ? OPER_BITS'(-mag_lo) : mag_lo;
               rsp_in.result_den = qb_ff[30:0];
               rsp_in.is_less = less_ff;
               rsp_in.is_equal = equal_ff;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      step_ff <= step_in;
      p_ff <= p_in;
      q_ff <= q_in;
      dd_ff <= dd_in;
      nn_ff <= nn_in;
      neg_ff <= neg_in;
      stat_ff <= stat_in;
      less_ff <= less_in;
      equal_ff <= equal_in;
      ga_ff <= ga_in;
      gb_ff <= gb_in;
      g_ff <= g_in;
      k_ff <= k_in;
      qa_ff <= qa_in;
      qb_ff <= qb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: front end, item queue, back end.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
//   channel   ports                    handshake
//   input     start, busy, req_data    taken when start is high and busy low
//   result    rsp_valid, rsp_data      one cycle wide, cannot be held off
//
// An item that ends early (zero denominator, unused action) goes from the
// queue straight to the result state. A compare, a zero result or a division
// by zero ends after the products and their combination. Otherwise the long
// path is four products on one 32x32 multiplier, a binary gcd at one step a
// cycle and bit-serial division of the 64-bit numerator and denominator.
// Reset is synchronous and empties the queue. Busy is high while the
// two-entry queue is full; the result side never stalls.
module rational_arithmetic_unit #(
   parameter int DATA_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   logic    push, pop, full, empty;
   job_type push_job, head;

   assign busy = full;

   rau_front #(.DATA_BITS(DATA_BITS)) u_front (
      .start    (start),
      .full     (full),
      .req_data (req_data),
      .push     (push),
      .job      (push_job)
   );

   rau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   rau_back #(.DATA_BITS(DATA_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> verif/rational_arithmetic_unit_test.sv
// Testbench for the rational arithmetic unit: directed and random fractions checked
// against an exact 64-bit predictor of the reduced result. Depends on rau_pkg.
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;
   import rau_pkg::*;

   typedef struct {
      bit        neg;
      bit [63:0] mag;
      bit [63:0] den;
   } fraction_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 250;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type expected_results[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      steady_sender;

   rational_arithmetic_unit u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Euclid on 64-bit magnitudes.
   function automatic bit [63:0] common_divisor(bit [63:0] a, bit [63:0] b);
      bit [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Lowest terms; zero becomes +0/1.
   function automatic fraction_type lowest_terms(bit neg, bit [63:0] mag, bit [63:0] den);
      fraction_type f;
      bit [63:0] g;
      if (mag == 0) begin
         f.neg = 1'b0;
         f.mag = 0;
         f.den = 1;
      end else begin
         g = common_divisor(mag, den);
         f.neg = neg;
         f.mag = mag / g;
         f.den = den / g;
      end
      return f;
   endfunction

   function automatic bit [63:0] magnitude(logic signed [31:0] v);
      longint w;
      w = v;
      return (w < 0) ? bit'(1) ? 64'(-w) : 64'(w) : 64'(w);
   endfunction

   function automatic fraction_type signed_sum(bit pneg, bit [63:0] p, bit qneg,
                                               bit [63:0] q, bit [63:0] den);
      if (pneg == qneg) return lowest_terms(pneg, p + q, den);
      if (p >= q) return lowest_terms(pneg, p - q, den);
      return lowest_terms(qneg, q - p, den);
   endfunction

   // Expected result of one item.
   function automatic rsp_type reduced_result(req_type r);
      rsp_type      o;
      fraction_type a;
      fraction_type b;
      fraction_type res;
      bit [63:0]    p;
      bit [63:0]    q;
      bit [63:0]    half;
      logic [1:0]   st;
      bit           less;
      bit           equal;
      st = ST_OK;
      less = 0;
      equal = 0;
      res.neg = 0;
      res.mag = 0;
      res.den = 1;
      half = 64'd1 << 31;
      if (r.action > ACT_CMP) begin
         st = ST_OK;
      end else if (r.left_den == 0 || (r.action != ACT_NORM && r.right_den == 0)) begin
         st = ST_ZERO_DEN;
      end else begin
         a = lowest_terms(r.left_num[31] != r.left_den[31], magnitude(r.left_num),
                          magnitude(r.left_den));
         if (r.action == ACT_NORM) begin
            b = lowest_terms(1'b0, 0, 1);
         end else begin
            b = lowest_terms(r.right_num[31] != r.right_den[31], magnitude(r.right_num),
                             magnitude(r.right_den));
         end
         p = a.mag * b.den;
         q = b.mag * a.den;
         case (r.action)
            ACT_NORM: res = a;
            ACT_ADD:  res = signed_sum(a.neg, p, b.neg, q, a.den * b.den);
            ACT_SUB:  res = signed_sum(a.neg, p, !b.neg, q, a.den * b.den);
            ACT_MUL:  res = lowest_terms(a.neg != b.neg, a.mag * b.mag, a.den * b.den);
            ACT_DIV: begin
               if (b.mag == 0) st = ST_DIV_ZERO;
               else res = lowest_terms(a.neg != b.neg, p, a.den * b.mag);
            end
            default: begin
               equal = (a.neg == b.neg) && (p == q);
               if (a.neg != b.neg) less = a.neg;
               else if (a.neg) less = p > q;
               else less = p < q;
            end
         endcase
         if (st == ST_OK &&
             !(res.mag <= (res.neg ? half : half - 1) && res.den <= half - 1)) begin
            st = ST_OVERFLOW;
         end
      end
      if (st != ST_OK) begin
         o = '0;
      end else begin
         o.result_num = res.neg ? 32'(-res.mag) : res.mag[31:0];
         o.result_den = res.den[30:0];
         o.is_less = less;
         o.is_equal = equal;
      end
      o.status = st;
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      error_count++;
      if (error_count <= 30)
         $display("mismatch in %s: got %0d, expected %0d", field, got, want);
   endtask

   // Each result is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.result_num !== want.result_num)
               report_mismatch("result_num", rsp_data.result_num, want.result_num);
            if (rsp_data.result_den !== want.result_den)
               report_mismatch("result_den", rsp_data.result_den, want.result_den);
            if (rsp_data.is_less !== want.is_less)
               report_mismatch("is_less", rsp_data.is_less, want.is_less);
            if (rsp_data.is_equal !== want.is_equal)
               report_mismatch("is_equal", rsp_data.is_equal, want.is_equal);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   // Watchdog on cycles in which no item is accepted and no result appears.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("rational_arithmetic_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one item; start stays high afterwards unless the next item idles first.
   task automatic send_item(logic [2:0] act, logic [31:0] ln, logic [31:0] ld,
                            logic [31:0] rn, logic [31:0] rd);
      req_type r;
      r.action = act;
      r.left_num = ln;
      r.left_den = ld;
      r.right_num = rn;
      r.right_den = rd;
      if (!steady_sender && $urandom_range(99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(reduced_result(r));
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(9))
         0, 1, 2: return 32'($signed($urandom_range(40)) - 20);
         3:       return 32'($signed($urandom_range(2000)) - 1000);
         4:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         5:       return $urandom_range(1) ? 32'h8000_0001 : 32'hFFFF_FFFF;
         6:       return $urandom() >> $urandom_range(31);
         default: return $urandom();
      endcase
   endfunction

   // Extremes of the operands and the special cases of every action.
   task automatic test_special_cases();
      send_item(ACT_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
      send_item(ACT_NORM, 32'h8000_0000, 32'h8000_0000, 5, 7);
      send_item(ACT_NORM, 6, -4, 1, 1);
      send_item(ACT_NORM, 0, -5, 3, 0);
      send_item(ACT_NORM, 3, 0, 1, 1);
      send_item(ACT_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      send_item(ACT_ADD, 1, 2, 1, 3);
      send_item(ACT_ADD, 1, 2, -1, 2);
      send_item(ACT_ADD, 1, 1, 1, 0);
      send_item(ACT_SUB, 32'h8000_0000, 1, 1, 1);
      send_item(ACT_SUB, -3, 4, -5, 6);
      send_item(ACT_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      send_item(ACT_MUL, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
      send_item(ACT_MUL, 4, -6, 9, 10);
      send_item(ACT_DIV, 7, 3, 0, -9);
      send_item(ACT_DIV, 7, 3, 14, -9);
      send_item(ACT_DIV, 1, 1, 0, 0);
      send_item(ACT_CMP, 1, 2, 2, 4);
      send_item(ACT_CMP, -1, 3, 1, 3);
      send_item(ACT_CMP, -1, 2, -1, 3);
      send_item(ACT_CMP, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFD);
      send_item(3'd6, 5, 0, 5, 0);
      send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Random items; one long stretch runs without sender gaps.
   task automatic test_random_items(int count);
      logic [2:0]  act;
      logic [31:0] ld;
      logic [31:0] rd;
      for (int i = 0; i < count; i++) begin
         steady_sender = (i >= count / 3) && (i < count / 2);
         act = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
         ld = random_operand();
         rd = random_operand();
         if ($urandom_range(29) == 0) ld = 0;
         if ($urandom_range(29) == 0) rd = 0;
         send_item(act, random_operand(), ld, random_operand(), rd);
         if (i == count / 4) wait_for_results();
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      steady_sender = 1'b0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      wait_for_results();
      test_random_items(880);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("rational_arithmetic_unit verification clean");
      end else begin
         $display("rational_arithmetic_unit verification failed");
      end
      $finish;
   end

endmodule
